>>> hw/rtl/jndc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jndc_pkg
// Shared constants and types for the Jalali new-year day and date check.
// ----------------------------------------------------------------------------
package jndc_pkg;

   localparam int YEAR_W = 13;
   localparam int YEAR_X_W = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W = 5;
   localparam int JDN_W = 22;
   localparam int CALC_W = 22;
   localparam int ABS_W = 20;
   localparam int RECIP_W = 21;
   localparam int QUOT_W = 10;
   localparam int DELTA_W = 11;
   localparam int SEG_COUNT = 12;
   localparam int SEG_LOW = 3;

   localparam logic signed [YEAR_X_W-1:0] YEAR_LOW = -14'sd1096;
   localparam logic signed [YEAR_X_W-1:0] YEAR_HIGH = 14'sd2327;
   localparam logic [JDN_W-1:0] EPOCH_DAY = 22'd1947954;
   localparam logic [JDN_W-1:0] LEAP_SPAN = 22'd366;
   localparam logic signed [CALC_W-1:0] DAYS_PER_YEAR = 22'sd365;
   localparam logic signed [CALC_W-1:0] CYCLE_MUL = 22'sd303;

   // ceil(2^31 / 1250): exact quotient for dividends below 2^20
   localparam logic [RECIP_W-1:0] DIV_RECIP = 21'd1717987;
   localparam int DIV_SHIFT = 31;

   localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_LAST31 = 4'd6;
   localparam logic [MONTH_W-1:0] MONTH_LAST30 = 4'd11;
   localparam logic [MONTH_W-1:0] MONTH_LAST = 4'd12;
   localparam logic [DAY_W-1:0] LEN_31 = 5'd31;
   localparam logic [DAY_W-1:0] LEN_30 = 5'd30;
   localparam logic [DAY_W-1:0] LEN_29 = 5'd29;

   localparam logic signed [YEAR_X_W-1:0] SEG_BREAK [SEG_COUNT] = '{
      -14'sd708, -14'sd221, -14'sd3, 14'sd6, 14'sd394, 14'sd720,
      14'sd786, 14'sd1145, 14'sd1635, 14'sd1701, 14'sd1866, 14'sd2328
   };

   localparam logic [DELTA_W-1:0] SEG_DELTA [SEG_COUNT] = '{
      11'd1108, 11'd1047, 11'd984, 11'd1249, 11'd952, 11'd891,
      11'd930, 11'd866, 11'd869, 11'd844, 11'd848, 11'd852
   };

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } stage_en_type;

endpackage

>>> hw/rtl/jndc_first_day.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jndc_first_day
// Three-stage pipeline giving the day number of a Persian year's first day:
// segment lookup, reciprocal multiply for the divide by 1250, final sum.
// ----------------------------------------------------------------------------
module jndc_first_day (
   input  logic                                    clock,
   input  jndc_pkg::stage_en_type                  stage_en,
   input  logic signed [jndc_pkg::YEAR_X_W-1:0]   year,
   output logic        [jndc_pkg::JDN_W-1:0]      first_day
);

   // stage 1: segment, dividend magnitude
   logic [jndc_pkg::DELTA_W-1:0]          delta;
   logic                                  minus_in;
   logic signed [jndc_pkg::CALC_W-1:0]    t_in;
   logic signed [jndc_pkg::CALC_W-1:0]    t_abs;
   logic                                  ok_in;

   logic [jndc_pkg::ABS_W-1:0]            a_ff;
   logic                                  neg1_ff;
   logic                                  minus1_ff;
   logic                                  ok1_ff;
   logic signed [jndc_pkg::YEAR_X_W-1:0]  y1_ff;

   always_comb begin
      delta = jndc_pkg::SEG_DELTA[jndc_pkg::SEG_COUNT-1];
      minus_in = 1'b0;
      for (int k = jndc_pkg::SEG_COUNT - 1; k >= 0; k--) begin
         if (year < jndc_pkg::SEG_BREAK[k]) begin
            delta = jndc_pkg::SEG_DELTA[k];
            minus_in = (k < jndc_pkg::SEG_LOW);
         end
      end
      t_in = jndc_pkg::CALC_W'(year) * jndc_pkg::CYCLE_MUL
           + $signed({{(jndc_pkg::CALC_W-jndc_pkg::DELTA_W){1'b0}}, delta});
      t_abs = t_in[jndc_pkg::CALC_W-1] ? -t_in : t_in;
      ok_in = (year >= jndc_pkg::YEAR_LOW) && (year <= jndc_pkg::YEAR_HIGH);
   end

   always_ff @(posedge clock) begin
      if (stage_en.s1) begin
         a_ff <= t_abs[jndc_pkg::ABS_W-1:0];
         neg1_ff <= t_in[jndc_pkg::CALC_W-1];
         minus1_ff <= minus_in;
         ok1_ff <= ok_in;
         y1_ff <= year;
      end
   end

   // stage 2: quotient and 365*year
   localparam int PROD_W = jndc_pkg::ABS_W + jndc_pkg::RECIP_W;

   logic [PROD_W-1:0]                     prod;
   logic signed [jndc_pkg::CALC_W-1:0]    y365_in;

   logic [jndc_pkg::QUOT_W-1:0]           q2_ff;
   logic                                  neg2_ff;
   logic                                  minus2_ff;
   logic                                  ok2_ff;
   logic signed [jndc_pkg::CALC_W-1:0]    y365_ff;

   assign prod = PROD_W'(a_ff) * PROD_W'(jndc_pkg::DIV_RECIP);
   assign y365_in = jndc_pkg::CALC_W'(y1_ff) * jndc_pkg::DAYS_PER_YEAR;

   always_ff @(posedge clock) begin
      if (stage_en.s2) begin
         q2_ff <= prod[jndc_pkg::DIV_SHIFT +: jndc_pkg::QUOT_W];
         neg2_ff <= neg1_ff;
         minus2_ff <= minus1_ff;
         ok2_ff <= ok1_ff;
         y365_ff <= y365_in;
      end
   end

   // stage 3: final sum, modulo 2^22
   logic [jndc_pkg::CALC_W-1:0] q_ext;
   logic [jndc_pkg::CALC_W-1:0] q_sgn;
   logic [jndc_pkg::CALC_W-1:0] sum;
   logic [jndc_pkg::JDN_W-1:0]  day_in;
   logic [jndc_pkg::JDN_W-1:0]  day_ff;

   always_comb begin
      q_ext = {{(jndc_pkg::CALC_W-jndc_pkg::QUOT_W){1'b0}}, q2_ff};
      q_sgn = neg2_ff ? -q_ext : q_ext;
      sum = jndc_pkg::EPOCH_DAY + $unsigned(y365_ff) + q_sgn
          - {{(jndc_pkg::CALC_W-1){1'b0}}, minus2_ff};
      day_in = ok2_ff ? sum : '0;
   end

   always_ff @(posedge clock) begin
      if (stage_en.s3) begin
         day_ff <= day_in;
      end
   end

   assign first_day = day_ff;

endmodule

>>> hw/rtl/jalali_new_year_and_date_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jalali_new_year_and_date_check
// Persian new-year day number, leap flag and date check, one date per cycle unless stalled.
// ----------------------------------------------------------------------------
// Input channel req_*: one beat per date (year, month, day in req_tdata).
// Result channel rsp_*: one beat per input beat, in order, carrying the
//   first-day number of the year, leap flag, date-valid and year-valid.
// Each beat passes the three first-day stages, then the output register.
// Throughput: one beat per cycle when not stalled; two copies of the first-day pipeline
//   (year and year+1) run in parallel, each with three constant multipliers.
// Each stage holds its beat only while the stage after it is full and
//   stalled, so bubbles are squeezed out and rsp_tready low back-pressures
//   req_tready only once the whole pipe is full.
// Reset: synchronous, active high; clears all valid bits. No other state.
// ----------------------------------------------------------------------------
module jalali_new_year_and_date_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // year_value[12:0], month_number[16:13], day_number[21:17]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // new_year_day[21:0], leap_year[22], date_valid[23],
                                    // year_valid[24]
);

   logic                             v1_ff, v2_ff, v3_ff, vo_ff;
   logic                             en_out;
   jndc_pkg::stage_en_type           stage_en;

   assign en_out = !vo_ff || rsp_tready;
   assign stage_en.s3 = !v3_ff || en_out;
   assign stage_en.s2 = !v2_ff || stage_en.s3;
   assign stage_en.s1 = !v1_ff || stage_en.s2;
   assign req_tready = stage_en.s1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (stage_en.s1) v1_ff <= req_tvalid;
         if (stage_en.s2) v2_ff <= v1_ff;
         if (stage_en.s3) v3_ff <= v2_ff;
         if (en_out) vo_ff <= v3_ff;
      end
   end

   logic signed [jndc_pkg::YEAR_W-1:0]   year_in;
   logic        [jndc_pkg::MONTH_W-1:0]  month_in;
   logic        [jndc_pkg::DAY_W-1:0]    day_in;
   logic signed [jndc_pkg::YEAR_X_W-1:0] year_cur;
   logic signed [jndc_pkg::YEAR_X_W-1:0] year_nxt;
   logic                                 yok_in;

   assign year_in = $signed(req_tdata[12:0]);
   assign month_in = req_tdata[16:13];
   assign day_in = req_tdata[21:17];
   assign year_cur = jndc_pkg::YEAR_X_W'(year_in);
   assign year_nxt = year_cur + 14'sd1;
   assign yok_in = (year_cur > jndc_pkg::YEAR_LOW) && (year_cur < jndc_pkg::YEAR_HIGH);

   logic [jndc_pkg::JDN_W-1:0] day_cur;
   logic [jndc_pkg::JDN_W-1:0] day_nxt;

   jndc_first_day u_cur (
      .clock     (clock),
      .stage_en  (stage_en),
      .year      (year_cur),
      .first_day (day_cur)
   );

   jndc_first_day u_nxt (
      .clock     (clock),
      .stage_en  (stage_en),
      .year      (year_nxt),
      .first_day (day_nxt)
   );

   // month, day and year-ok ride alongside the first-day pipe
   logic [jndc_pkg::MONTH_W-1:0] m1_ff, m2_ff, m3_ff;
   logic [jndc_pkg::DAY_W-1:0]   d1_ff, d2_ff, d3_ff;
   logic                         y1_ff, y2_ff, y3_ff;

   always_ff @(posedge clock) begin
      if (stage_en.s1) begin
         m1_ff <= month_in;
         d1_ff <= day_in;
         y1_ff <= yok_in;
      end
      if (stage_en.s2) begin
         m2_ff <= m1_ff;
         d2_ff <= d1_ff;
         y2_ff <= y1_ff;
      end
      if (stage_en.s3) begin
         m3_ff <= m2_ff;
         d3_ff <= d2_ff;
         y3_ff <= y2_ff;
      end
   end

   // output stage: leap flag and date check
   logic                       leap_in;
   logic [jndc_pkg::DAY_W-1:0] mlen;
   logic                       dok_in;

   logic [jndc_pkg::JDN_W-1:0] nyd_ff;
   logic                       leap_ff;
   logic                       dok_ff;
   logic                       yok_ff;

   always_comb begin
      leap_in = ({1'b0, day_nxt} == ({1'b0, day_cur} + {1'b0, jndc_pkg::LEAP_SPAN}));
      if (m3_ff <= jndc_pkg::MONTH_LAST31) begin
         mlen = jndc_pkg::LEN_31;
      end else if (m3_ff <= jndc_pkg::MONTH_LAST30) begin
         mlen = jndc_pkg::LEN_30;
      end else begin
         mlen = leap_in ? jndc_pkg::LEN_30 : jndc_pkg::LEN_29;
      end
      dok_in = y3_ff && (m3_ff >= jndc_pkg::MONTH_FIRST) && (m3_ff <= jndc_pkg::MONTH_LAST)
            && (d3_ff != '0) && (d3_ff <= mlen);
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         nyd_ff <= day_cur;
         leap_ff <= leap_in;
         dok_ff <= dok_in;
         yok_ff <= y3_ff;
      end
   end

   assign rsp_tvalid = vo_ff;
   assign rsp_tdata = {7'd0, yok_ff, dok_ff, leap_ff, nyd_ff};

   a_date_needs_year : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!dok_ff || yok_ff))
      else $error("date valid without year valid");

   a_year_has_day : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && yok_ff) |-> (nyd_ff != '0))
      else $error("valid year with zero first day");

   a_leap_has_day : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && leap_ff) |-> (nyd_ff != '0))
      else $error("leap year with zero first day");

   a_stage3_holds : assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !stage_en.s3) |=> v3_ff)
      else $error("stalled stage 3 beat lost");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream testbench for the Jalali new-year day number and date check.
// ----------------------------------------------------------------------------
// Dates go in on req_*, and each result beat on rsp_* is compared field by
// field with the oldest pending expectation. Expectations come from an
// in-bench calendar predictor, or are typed into the directed table where
// the result is obvious (years outside the supported span). The directed
// rows are followed by random dates aimed at the segment breaks, the span
// edges and the month-length limits, plus full-range noise. The sender
// runs in random bursts. The receiver stalls in random modes and once holds
// off long enough to back-pressure the input.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int NUM_DIRECTED = 25;
   localparam int NUM_RANDOM = 1200;
   localparam int CYCLE_LIMIT = 200000;
   localparam int REPORT_LIMIT = 10;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_AFTER = 400;
   localparam int HOLD_CYCLES = 100;

   localparam int SPAN_LOW = -1096;
   localparam int SPAN_HIGH = 2327;
   localparam int JDN_EPOCH = 1947954;
   localparam int YEAR_DAYS = 365;
   localparam int CYCLE_NUM = 303;
   localparam int CYCLE_DEN = 1250;
   localparam int LEAP_DAYS = 366;
   localparam int SHORT_SEGS = 3;

   localparam int SEG_UPPER [12] = '{
      -708, -221, -3, 6, 394, 720, 786, 1145, 1635, 1701, 1866, 2328
   };
   localparam int SEG_OFFSET [12] = '{
      1108, 1047, 984, 1249, 952, 891, 930, 866, 869, 844, 848, 852
   };

   typedef enum int {
      RX_ALWAYS,
      RX_LIGHT,
      RX_HEAVY
   } rx_mode_type;

   // matches rsp_tdata[24:0]
   typedef struct packed {
      logic        year_valid;
      logic        date_valid;
      logic        leap_year;
      logic [21:0] new_year_day;
   } jalali_result_type;

   typedef struct packed {
      logic signed [12:0] year;
      logic [3:0]         month;
      logic [4:0]         day;
      logic               typed;
      jalali_result_type  want;
   } date_row_type;

   localparam date_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      '{13'h1000,     4'd1,  5'd1,  1'b1, '0},
      '{13'sd4095,    4'd12, 5'd31, 1'b1, '0},
      '{-13'sd1097,   4'd1,  5'd1,  1'b1, '0},
      '{13'sd2328,    4'd1,  5'd1,  1'b1, '0},
      '{-13'sd1096,   4'd1,  5'd1,  1'b0, '0},
      '{-13'sd1095,   4'd12, 5'd29, 1'b0, '0},
      '{13'sd2327,    4'd12, 5'd30, 1'b0, '0},
      '{13'sd2326,    4'd12, 5'd30, 1'b0, '0},
      '{13'sd1403,    4'd12, 5'd30, 1'b0, '0},
      '{13'sd1402,    4'd12, 5'd30, 1'b0, '0},
      '{13'sd1402,    4'd0,  5'd1,  1'b0, '0},
      '{13'sd1402,    4'd13, 5'd1,  1'b0, '0},
      '{13'sd1402,    4'd15, 5'd31, 1'b0, '0},
      '{13'sd1402,    4'd1,  5'd0,  1'b0, '0},
      '{13'sd1402,    4'd6,  5'd31, 1'b0, '0},
      '{13'sd1402,    4'd7,  5'd31, 1'b0, '0},
      '{13'sd1402,    4'd11, 5'd30, 1'b0, '0},
      '{13'sd1402,    4'd12, 5'd29, 1'b0, '0},
      '{-13'sd4,      4'd1,  5'd1,  1'b0, '0},
      '{-13'sd3,      4'd6,  5'd31, 1'b0, '0},
      '{13'sd1,       4'd7,  5'd30, 1'b0, '0},
      '{13'sd5,       4'd12, 5'd30, 1'b0, '0},
      '{13'sd6,       4'd12, 5'd30, 1'b0, '0},
      '{-13'sd709,    4'd3,  5'd15, 1'b0, '0},
      '{-13'sd708,    4'd3,  5'd15, 1'b0, '0}
   };

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;    // year_value[12:0], month_number[16:13], day_number[21:17]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;    // new_year_day[21:0], leap_year[22], date_valid[23],
                              // year_valid[24]

   jalali_result_type pending_results [$];
   int                mismatch_count = 0;
   int                dates_accepted = 0;
   int                cycle_count = 0;
   int                burst_left = 0;

   jalali_new_year_and_date_check DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // calendar predictor
   // ------------------------------------------------------------------------
   function automatic int new_year_jdn(input int y);
      int jdn;
      if (y < SPAN_LOW || y > SPAN_HIGH) begin
         return 0;
      end
      for (int k = 0; k < 12; k++) begin
         if (y < SEG_UPPER[k]) begin
            jdn = JDN_EPOCH + y * YEAR_DAYS + (SEG_OFFSET[k] + y * CYCLE_NUM) / CYCLE_DEN;
            if (k < SHORT_SEGS) begin
               jdn = jdn - 1;
            end
            return jdn;
         end
      end
      return 0;
   endfunction

   function automatic jalali_result_type jalali_predict(input int y, input int m, input int d);
      jalali_result_type r;
      int                jdn;
      int                month_len;
      jdn = new_year_jdn(y);
      r.new_year_day = jdn[21:0];
      r.leap_year = ((new_year_jdn(y + 1) - jdn) == LEAP_DAYS);
      r.year_valid = (y > SPAN_LOW) && (y < SPAN_HIGH);
      if (m <= 6) begin
         month_len = 31;
      end else if (m <= 11) begin
         month_len = 30;
      end else begin
         month_len = r.leap_year ? 30 : 29;
      end
      r.date_valid = r.year_valid && m >= 1 && m <= 12 && d >= 1 && d <= month_len;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // random date fields
   // ------------------------------------------------------------------------
   function automatic logic [12:0] pick_year();
      int y;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: y = int'($urandom_range(0, SPAN_HIGH - SPAN_LOW)) + SPAN_LOW;
         5: y = (($urandom_range(0, 1) == 0) ? SPAN_LOW : SPAN_HIGH)
                + int'($urandom_range(0, 2)) - 1;
         6, 7: y = SEG_UPPER[$urandom_range(0, 11)] + int'($urandom_range(0, 2)) - 1;
         default: y = int'($urandom_range(0, 8191)) - 4096;
      endcase
      return y[12:0];
   endfunction

   function automatic logic [3:0] pick_month();
      if ($urandom_range(0, 9) < 8) begin
         return 4'($urandom_range(1, 12));
      end
      return 4'($urandom_range(0, 15));
   endfunction

   function automatic logic [4:0] pick_day();
      case ($urandom_range(0, 7))
         0, 1, 2, 3: return 5'($urandom_range(1, 28));
         4, 5, 6: return 5'($urandom_range(28, 31));
         default: return 5'($urandom_range(0, 31));
      endcase
   endfunction

   function automatic void note_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%0t: %s", $realtime, msg);
      end
   endfunction

   // ------------------------------------------------------------------------
   // sender: one beat per call, random gaps between bursts
   // ------------------------------------------------------------------------
   task automatic offer_date(input logic signed [12:0] y, input logic [3:0] m,
                             input logic [4:0] d, input logic typed,
                             input jalali_result_type want);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      @(negedge clock);
      while (gap > 0) begin
         req_tvalid <= 1'b0;
         gap--;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, d, m, y};
      do begin
         @(posedge clock);
      end while (!(req_tvalid && req_tready));
      pending_results.push_back(typed ? want : jalali_predict(int'(y), int'(m), int'(d)));
      dates_accepted++;
      burst_left--;
   endtask

   // ------------------------------------------------------------------------
   // receiver: random stall modes plus one long hold-off
   // ------------------------------------------------------------------------
   initial begin
      rx_mode_type mode;
      int          mode_left;
      int          hold_left;
      logic        held_once;
      mode = RX_ALWAYS;
      mode_left = 0;
      hold_left = 0;
      held_once = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held_once && dates_accepted >= HOLD_AFTER) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode = rx_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(20, 100);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               RX_ALWAYS: rsp_tready <= 1'b1;
               RX_LIGHT: rsp_tready <= ($urandom_range(0, 3) != 0);
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // result checker
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      jalali_result_type got;
      jalali_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[24:0];
         if (pending_results.size() == 0) begin
            note_failure($sformatf("unexpected beat: data %h", rsp_tdata));
         end else begin
            want = pending_results.pop_front();
            if (got.new_year_day !== want.new_year_day || got.leap_year !== want.leap_year ||
                got.date_valid !== want.date_valid || got.year_valid !== want.year_valid) begin
               note_failure($sformatf(
                  {"mismatch: exp day %0d leap %b date %b year %b, ",
                   "got day %0d leap %b date %b year %b"},
                  want.new_year_day, want.leap_year, want.date_valid, want.year_valid,
                  got.new_year_day, got.leap_year, got.date_valid, got.year_valid));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[jalali_new_year_and_date_check] ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         offer_date(DIRECTED_ROWS[i].year, DIRECTED_ROWS[i].month, DIRECTED_ROWS[i].day,
                    DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
      end

      for (int i = 0; i < NUM_RANDOM; i++) begin
         offer_date(pick_year(), pick_month(), pick_day(), 1'b0, '0);
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("[jalali_new_year_and_date_check] OK");
      end else begin
         $display("[jalali_new_year_and_date_check] ERROR");
      end
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/jndc_pkg.sv
hw/rtl/jndc_first_day.sv
hw/rtl/jalali_new_year_and_date_check.sv
verif/tb_top.sv
